>>> src/u16u8_pkg.sv
`timescale 1ns / 1ps

package u16u8_pkg;

  // Longest byte run that one code unit can cause: a flushed high
  // surrogate (three bytes) followed by a three-byte unit.
  localparam int unsigned MaxBytes = 6;

  typedef logic [7:0] byte_t;

  // One queued job: the bytes that a single accepted unit causes, in order
  // from entry 0, the number of them and whether the last ends the string.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     str_end;
  } job_t;

  // Status that the queue reports to its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Classes of a single code unit.
  typedef enum logic [2:0] {
    CLS_END,
    CLS_ONE,
    CLS_TWO,
    CLS_HIGH,
    CLS_THREE
  } unit_cls_t;

  localparam logic [15:0] SurrMask = 16'hFC00;
  localparam logic [15:0] LowBase  = 16'hDC00;
  localparam logic [7:0]  LeadTwo   = 8'hC0;
  localparam logic [7:0]  LeadThree = 8'hE0;
  localparam logic [7:0]  LeadFour  = 8'hF0;
  localparam logic [7:0]  ContMark  = 8'h80;

endpackage

>>> src/u16u8_front.sv
`timescale 1ns / 1ps

module u16u8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [15:0]       in_code_unit,
  output logic              push,
  output u16u8_pkg::job_t   push_job
);
  import u16u8_pkg::*;

  logic        pend_r, pend_nxt;
  logic [15:0] held_r, held_nxt;

  logic        accept;
  logic        is_low;
  logic        pair;
  logic        flush;
  unit_cls_t   cls;
  logic [2:0][7:0] tail;
  logic [1:0]  tail_cnt;
  logic [20:0] cp;
  job_t        job;

  assign accept = in_valid && !in_stall;
  assign is_low = (in_code_unit & SurrMask) == LowBase;
  assign pair   = pend_r && is_low;
  assign flush  = pend_r && !is_low;
  assign cp     = 21'h10000 + {1'b0, held_r[9:0], in_code_unit[9:0]};

  always_comb begin
    if (in_code_unit == 16'h0000) begin
      cls = CLS_END;
    end else if (in_code_unit inside {[16'h0001:16'h007F]}) begin
      cls = CLS_ONE;
    end else if (in_code_unit inside {[16'h0080:16'h07FF]}) begin
      cls = CLS_TWO;
    end else if (in_code_unit inside {[16'hD800:16'hDBFF]}) begin
      cls = CLS_HIGH;
    end else begin
      cls = CLS_THREE;
    end
  end

  // Bytes of the current unit on its own, as the first entries of tail.
  always_comb begin
    tail     = '0;
    tail_cnt = 2'd0;
    case (cls)
      CLS_END: begin
        tail_cnt = 2'd1;
      end
      CLS_ONE: begin
        tail[0]  = in_code_unit[7:0];
        tail_cnt = 2'd1;
      end
      CLS_TWO: begin
        tail[0]  = LeadTwo | {3'b000, in_code_unit[10:6]};
        tail[1]  = ContMark | {2'b00, in_code_unit[5:0]};
        tail_cnt = 2'd2;
      end
      CLS_HIGH: begin
        tail_cnt = 2'd0;
      end
      CLS_THREE: begin
        tail[0]  = LeadThree | {4'h0, in_code_unit[15:12]};
        tail[1]  = ContMark | {2'b00, in_code_unit[11:6]};
        tail[2]  = ContMark | {2'b00, in_code_unit[5:0]};
        tail_cnt = 2'd3;
      end
      default: begin
        tail_cnt = 2'd0;
      end
    endcase
  end

  always_comb begin
    job = '0;
    if (pair) begin
      job.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
      job.bytes[1] = ContMark | {2'b00, cp[17:12]};
      job.bytes[2] = ContMark | {2'b00, cp[11:6]};
      job.bytes[3] = ContMark | {2'b00, cp[5:0]};
      job.cnt      = 3'd4;
    end else if (flush) begin
      job.bytes[0] = LeadThree | {4'h0, held_r[15:12]};
      job.bytes[1] = ContMark | {2'b00, held_r[11:6]};
      job.bytes[2] = ContMark | {2'b00, held_r[5:0]};
      job.bytes[3] = tail[0];
      job.bytes[4] = tail[1];
      job.bytes[5] = tail[2];
      job.cnt      = 3'd3 + {1'b0, tail_cnt};
      job.str_end  = (cls == CLS_END);
    end else begin
      job.bytes[0] = tail[0];
      job.bytes[1] = tail[1];
      job.bytes[2] = tail[2];
      job.cnt      = {1'b0, tail_cnt};
      job.str_end  = (cls == CLS_END);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (accept) begin
      pend_nxt = !pair && (cls == CLS_HIGH);
      if (!pair && (cls == CLS_HIGH)) begin
        held_nxt = in_code_unit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
    held_r <= held_nxt;
  end

  assign push     = accept && (job.cnt != 3'd0);
  assign push_job = job;

endmodule

>>> src/u16u8_fifo.sv
`timescale 1ns / 1ps

module u16u8_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  u16u8_pkg::job_t        push_job,
  input  logic                   pop,
  output u16u8_pkg::job_t        head_job,
  output u16u8_pkg::fifo_stat_t  stat
);
  import u16u8_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head_job   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("job queue read while empty");

endmodule

>>> src/u16u8_back.sv
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  u16u8_pkg::job_t        head_job,
  input  u16u8_pkg::fifo_stat_t  stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  output logic                   out_string_end
);
  import u16u8_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       end_r, end_nxt;
  logic       busy_r, busy_nxt;

  logic       ov_r, ov_nxt;
  byte_t      ob_r, ob_nxt;
  logic       orl_r, orl_nxt;
  logic       ose_r, ose_nxt;

  logic       adv;
  logic       last;
  logic       take;

  assign adv  = !ov_r || !out_stall;
  assign last = busy_r && (cnt_r == 3'd1);
  assign take = !busy_r || (adv && last);
  assign pop  = take && !stat.empty;

  always_comb begin
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    orl_nxt = orl_r;
    ose_nxt = ose_r;
    if (adv) begin
      ov_nxt  = busy_r;
      ob_nxt  = bytes_r[0];
      orl_nxt = last;
      ose_nxt = last && end_r;
    end
  end

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    busy_nxt  = busy_r;
    if (pop) begin
      bytes_nxt = head_job.bytes;
      cnt_nxt   = head_job.cnt;
      end_nxt   = head_job.str_end;
      busy_nxt  = 1'b1;
    end else if (adv && busy_r) begin
      bytes_nxt = {8'h00, bytes_r[MaxBytes-1:1]};
      cnt_nxt   = cnt_r - 3'd1;
      busy_nxt  = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    bytes_r <= bytes_nxt;
    cnt_r   <= cnt_nxt;
    end_r   <= end_nxt;
    ob_r    <= ob_nxt;
    orl_r   <= orl_nxt;
    ose_r   <= ose_nxt;
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_run_last   = orl_r;
  assign out_string_end = ose_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ose_r |-> orl_r && (ob_r == 8'h00))
    else $error("string end flagged on a byte that does not close its run");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 3'd0) && (cnt_r <= 3'(MaxBytes)))
    else $error("serializer busy with a bad byte count");

endmodule

>>> src/utf16_to_utf8_encoder_unit.sv
`timescale 1ns / 1ps

// UTF-16 to UTF-8 encoder. Each input transfer carries one 16-bit code unit;
// each output transfer carries one UTF-8 byte, with run_last marking the last
// byte caused by a unit and string_end marking the terminating zero byte that
// a zero unit produces. A high surrogate is held and produces nothing until
// the next unit: a following low surrogate turns the pair into four bytes,
// anything else first flushes the held unit as three bytes. Lone surrogates
// are encoded as three bytes. Rate: the output side moves one byte per cycle
// unless out_stall holds it, so a unit that causes n bytes (one to six) keeps
// the byte serializer busy until all n have gone out; a held high surrogate
// does not occupy it. The input side takes a unit in any cycle in which the
// two-entry job queue between the classifier and the serializer has room, so
// short bursts of units are accepted back to back. With the serializer idle,
// a unit's first byte passes the job queue, serializer and output register.
module utf16_to_utf8_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end
);
  import u16u8_pkg::*;

  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       head_job;
  fifo_stat_t stat;

  // The classifier only stalls when the job queue has no free entry.
  assign in_stall = stat.full;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .push         (push),
    .push_job     (push_job)
  );

  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

>>> test/utf8_byte_checker.sv
`timescale 1ns / 1ps

module utf8_byte_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_run_last,
  input  logic        out_string_end,
  output int unsigned pending_bytes,
  output int unsigned error_count
);
  import u16u8_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  string_end;
  } utf8_byte_t;

  utf8_byte_t  utf8_queue[$];
  logic        high_held;
  logic [15:0] held_unit;

  function automatic byte_t three_byte_form(input logic [15:0] u, input int idx);
    byte_t b;
    case (idx)
      0:       b = LeadThree | {4'h0, u[15:12]};
      1:       b = ContMark | {2'b00, u[11:6]};
      default: b = ContMark | {2'b00, u[5:0]};
    endcase
    return b;
  endfunction

  // Works out the bytes that one accepted unit causes and queues them.
  task automatic encode_unit(input logic [15:0] u);
    byte_t       run_bytes[6];
    int          n;
    logic        ends_string;
    logic [20:0] point;
    utf8_byte_t  entry;
    n = 0;
    ends_string = 1'b0;
    if (high_held && (u & SurrMask) == LowBase) begin
      high_held = 1'b0;
      point = 21'h10000 + {1'b0, held_unit[9:0], u[9:0]};
      held_unit = '0;
      run_bytes[0] = LeadFour | {5'd0, point[20:18]};
      run_bytes[1] = ContMark | {2'b00, point[17:12]};
      run_bytes[2] = ContMark | {2'b00, point[11:6]};
      run_bytes[3] = ContMark | {2'b00, point[5:0]};
      n = 4;
    end else begin
      if (high_held) begin
        for (int i = 0; i < 3; i++) run_bytes[i] = three_byte_form(held_unit, i);
        n = 3;
        high_held = 1'b0;
        held_unit = '0;
      end
      if (u == 16'h0000) begin
        run_bytes[n] = 8'h00;
        n = n + 1;
        ends_string = 1'b1;
      end else if (u[15:7] == '0) begin
        run_bytes[n] = u[7:0];
        n = n + 1;
      end else if (u[15:11] == '0) begin
        run_bytes[n] = LeadTwo | {2'b00, u[11:6]};
        run_bytes[n+1] = ContMark | {2'b00, u[5:0]};
        n = n + 2;
      end else if ((u & SurrMask) == 16'hD800) begin
        high_held = 1'b1;
        held_unit = u;
      end else begin
        for (int i = 0; i < 3; i++) run_bytes[n+i] = three_byte_form(u, i);
        n = n + 3;
      end
    end
    for (int i = 0; i < n; i++) begin
      entry.data = run_bytes[i];
      entry.run_last = (i == n - 1);
      entry.string_end = ends_string && (i == n - 1);
      utf8_queue.push_back(entry);
    end
  endtask

  task automatic note_error();
    error_count = error_count + 1;
  endtask

  always @(posedge clk) begin
    utf8_byte_t want;
    if (!rst_n) begin
      utf8_queue.delete();
      high_held = 1'b0;
      held_unit = '0;
      error_count = 0;
    end else begin
      // A byte can never belong to a unit taken at the same edge, so the
      // output side is checked before the input side is predicted.
      if (out_valid && !out_stall) begin
        if (utf8_queue.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %02h last %0b end %0b",
                   $time, out_byte, out_run_last, out_string_end);
          note_error();
        end else begin
          want = utf8_queue.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_byte);
            note_error();
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: out_run_last mismatch, expected %0b, actual %0b",
                     $time, want.run_last, out_run_last);
            note_error();
          end
          if (out_string_end !== want.string_end) begin
            $display("%0t: out_string_end mismatch, expected %0b, actual %0b",
                     $time, want.string_end, out_string_end);
            note_error();
          end
        end
      end
      if (in_valid && !in_stall) encode_unit(in_code_unit);
    end
    pending_bytes = utf8_queue.size();
  end

endmodule

>>> test/utf16_to_utf8_encoder_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the UTF-16 to UTF-8 encoder. The byte checker
// beside the block does all of the prediction and comparison; this module
// only feeds code units, throttles the byte side and decides the outcome.
module utf16_to_utf8_encoder_unit_tb;
  import u16u8_pkg::*;

  // Number of random code units after the directed part.
  localparam int unsigned RandomUnits = 104;
  // Cycles without any transfer on either channel before the run is abandoned.
  // The slowest correct stretch is a long run of idle or stall draws at 80
  // percent, which stays far below this.
  localparam int unsigned QuietLimit = 4000;
  // Extra cycles after the last expected byte, to catch stray output.
  localparam int unsigned DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_code_unit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_string_end;

  int unsigned pending_bytes;
  int unsigned error_count;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned units_sent = 0;
  int unsigned quiet_cycles = 0;

  logic [15:0] directed_units [0:24];

  always #5 clk = ~clk;

  utf16_to_utf8_encoder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end)
  );

  utf8_byte_checker byte_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end),
    .pending_bytes (pending_bytes),
    .error_count   (error_count)
  );

  // The byte side stalls at random, at the rate that the current phase sets.
  // It is changed on the falling edge so that the block sees a settled value.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: any transfer on either channel restarts the count. A hung
  // block, or one that loses bytes, stops both channels and trips it.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one code unit and holds it until the block takes it. The task
  // starts and ends on a falling edge; valid is left high at the end so that
  // the next call either replaces the payload or drops valid, never both.
  task automatic send_unit(input logic [15:0] unit);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_code_unit <= unit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    units_sent = units_sent + 1;
    @(negedge clk);
  endtask

  // Stops offering units until the checker has seen every predicted byte.
  // A held high surrogate owes nothing yet, so it may still sit in the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_bytes != 0) @(negedge clk);
  endtask

  // One random pick. Well-formed surrogate pairs make up a good share so that
  // the four-byte path gets plenty of traffic; full 16-bit noise covers lone
  // and unpaired surrogates, and occasional zero units terminate strings,
  // sometimes right behind a held high surrogate.
  task automatic send_random();
    int unsigned pick;
    logic [15:0] unit;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_unit(16'($urandom_range(16'h007F, 16'h0001)));
    end else if (pick < 40) begin
      send_unit(16'($urandom_range(16'h07FF, 16'h0080)));
    end else if (pick < 60) begin
      send_unit(16'($urandom_range(16'hFFFF, 16'h0800)));
    end else if (pick < 85) begin
      send_unit(16'($urandom_range(16'hDBFF, 16'hD800)));
      send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)));
    end else if (pick < 95) begin
      unit = 16'($urandom());
      send_unit(unit);
    end else begin
      send_unit(16'h0000);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = units_sent + count;
    while (units_sent < stop_at) send_random();
  endtask

  initial begin
    // Directed part: range edges of each byte length, both ends of the
    // surrogate ranges, lone low surrogates, a high surrogate followed by an
    // ordinary unit, by another high surrogate, by a three-byte unit (the
    // six-byte case) and by a zero unit, and a plain terminator.
    directed_units = '{
      16'h0041, 16'h007F, 16'h0001, 16'h0080, 16'h07FF,
      16'h0800, 16'hFFFF, 16'hD7FF, 16'hE000,
      16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
      16'hDC00, 16'hDFFF,
      16'hD801, 16'h0041,
      16'hD802, 16'hD803, 16'hDC05,
      16'hD806, 16'h4E2D,
      16'hD804, 16'h0000,
      16'h0000
    };

    // Synchronous reset, released on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First phase: the sender idles now and then, the receiver mostly stalls.
    sender_idle_pct = 24;
    receiver_stall_pct = 80;
    foreach (directed_units[i]) send_unit(directed_units[i]);
    wait_drained();
    run_random(RandomUnits / 3);

    // Second phase: the roles swap, so the block mostly waits on input.
    sender_idle_pct = 80;
    receiver_stall_pct = 24;
    run_random(RandomUnits / 3);
    wait_drained();

    // Last phase: no idling or stalling by the bench, so transfers run back to back wherever the job queue has room.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(RandomUnits - 2 * (RandomUnits / 3));
    send_unit(16'h0000);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_bytes != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> utf16_to_utf8_encoder_unit.f
src/u16u8_pkg.sv
src/u16u8_front.sv
src/u16u8_fifo.sv
src/u16u8_back.sv
src/utf16_to_utf8_encoder_unit.sv
test/utf8_byte_checker.sv
test/utf16_to_utf8_encoder_unit_tb.sv
